// File: src/stt_pkg.sv
// Shared types, constants and helper functions for the source text tokenizer.
// No dependencies; every other file in src imports this package.
package stt_pkg;

    localparam int SOURCE_BYTES = 65536;
    localparam logic [15:0] POS_LIMIT =
        ((SOURCE_BYTES - 1) > 65535) ? 16'hFFFF : 16'(SOURCE_BYTES - 1);
    localparam logic [15:0] CNT_LIMIT = 16'hFFFF;

    localparam logic [7:0] CH_EQUALS = 8'h3D;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;

    localparam logic [15:0] TULIS_LEN = 16'd5;
    localparam logic [15:0] BIAR_LEN  = 16'd4;

    typedef enum logic [2:0] {
        KIND_END,
        KIND_EQUALS,
        KIND_STRING,
        KIND_NUMBER,
        KIND_IDENT,
        KIND_TULIS,
        KIND_BIAR,
        KIND_UNKNOWN
    } t_kind;

    typedef struct packed {
        logic [7:0] ch;
        logic       zero;
        logic       digit;
        logic       alpha;
        logic       space;
        logic       newline;
        logic       equals;
        logic       quote;
        logic       under;
    } t_cls;

    typedef struct packed {
        t_kind       kind;
        logic [15:0] start;
        logic [15:0] length;
        logic [15:0] line;
        logic        last;
    } t_token;

    function automatic logic [15:0] sat_inc(input logic [15:0] v, input logic [15:0] lim);
        return (v >= lim) ? lim : v + 16'd1;
    endfunction

    function automatic logic tulis_match(input logic [15:0] idx, input logic [7:0] c);
        logic ok;
        unique case (idx)
            16'd0:   ok = (c == "t");
            16'd1:   ok = (c == "u");
            16'd2:   ok = (c == "l");
            16'd3:   ok = (c == "i");
            16'd4:   ok = (c == "s");
            default: ok = 1'b0;
        endcase
        return ok;
    endfunction

    function automatic logic biar_match(input logic [15:0] idx, input logic [7:0] c);
        logic ok;
        unique case (idx)
            16'd0:   ok = (c == "b");
            16'd1:   ok = (c == "i");
            16'd2:   ok = (c == "a");
            16'd3:   ok = (c == "r");
            default: ok = 1'b0;
        endcase
        return ok;
    endfunction

endpackage

// File: src/stt_classify.sv
// Front end: sorts one source byte into character classes.
// Depends on stt_pkg.
module stt_classify (
    input  logic [7:0]    i_byte,
    output stt_pkg::t_cls o_cls
);
    import stt_pkg::*;

    always_comb begin
        o_cls.ch      = i_byte;
        o_cls.zero    = (i_byte == 8'h00);
        o_cls.digit   = (i_byte >= "0") && (i_byte <= "9");
        o_cls.alpha   = ((i_byte >= "a") && (i_byte <= "z")) ||
                        ((i_byte >= "A") && (i_byte <= "Z"));
        o_cls.space   = (i_byte == CH_SPACE) || ((i_byte >= CH_TAB) && (i_byte <= CH_CR));
        o_cls.newline = (i_byte == CH_LF);
        o_cls.equals  = (i_byte == CH_EQUALS);
        o_cls.quote   = (i_byte == CH_QUOTE);
        o_cls.under   = (i_byte == CH_UNDER);
    end

endmodule

// File: src/stt_cls_fifo.sv
// Four-entry queue of classified bytes between the front end and the scanner.
// Depends on stt_pkg.
module stt_cls_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  stt_pkg::t_cls i_data,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_empty,
    output stt_pkg::t_cls o_data
);
    import stt_pkg::*;

    t_cls       r_mem [4];
    logic [1:0] r_wp;
    logic [1:0] r_rp;
    logic [2:0] r_cnt;
    logic       push_ok;
    logic       pop_ok;

    assign o_full  = (r_cnt == 3'd4);
    assign o_empty = (r_cnt == 3'd0);
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 2'd0;
            r_rp  <= 2'd0;
            r_cnt <= 3'd0;
        end else begin
            if (push_ok) begin
                r_wp <= r_wp + 2'd1;
            end
            if (pop_ok) begin
                r_rp <= r_rp + 2'd1;
            end
            r_cnt <= r_cnt + 3'(push_ok) - 3'(pop_ok);
        end
    end

endmodule

// File: src/stt_tok_fifo.sv
// Four-entry token queue with two write ports and one read port.
// Depends on stt_pkg.
module stt_tok_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_wr0,
    input  stt_pkg::t_token i_tok0,
    input  logic            i_wr1,
    input  stt_pkg::t_token i_tok1,
    output logic            o_room2,
    input  logic            i_pop,
    output logic            o_empty,
    output stt_pkg::t_token o_tok
);
    import stt_pkg::*;

    t_token     r_mem [4];
    logic [1:0] r_wp;
    logic [1:0] r_rp;
    logic [2:0] r_cnt;
    logic       pop_ok;

    assign o_room2 = (r_cnt <= 3'd2);
    assign o_empty = (r_cnt == 3'd0);
    assign pop_ok  = i_pop && !o_empty;
    assign o_tok   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_wr0) begin
            r_mem[r_wp] <= i_tok0;
        end
        if (i_wr1) begin
            r_mem[r_wp + 2'd1] <= i_tok1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 2'd0;
            r_rp  <= 2'd0;
            r_cnt <= 3'd0;
        end else begin
            r_wp <= r_wp + 2'(i_wr0) + 2'(i_wr1);
            if (pop_ok) begin
                r_rp <= r_rp + 2'd1;
            end
            r_cnt <= r_cnt + 3'(i_wr0) + 3'(i_wr1) - 3'(pop_ok);
        end
    end

endmodule

// File: src/stt_scan.sv
// Back end: scanner state machine that turns classified bytes into tokens.
// Depends on stt_pkg; emits up to two tokens per byte.
module stt_scan (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_fire,
    input  stt_pkg::t_cls   i_cls,
    output logic            o_wr0,
    output stt_pkg::t_token o_tok0,
    output logic            o_wr1,
    output stt_pkg::t_token o_tok1
);
    import stt_pkg::*;

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_STRING,
        MODE_NUMBER,
        MODE_IDENT
    } t_mode;

    t_mode       r_mode, n_mode;
    logic [15:0] r_pos, n_pos;
    logic [15:0] r_line, n_line;
    logic [15:0] r_pstart, n_pstart;
    logic [15:0] r_plen, n_plen;
    logic        r_tulis, n_tulis;
    logic        r_biar, n_biar;

    t_token a_tok, b_tok;
    logic   a_vld, b_vld;
    logic   idle_path;
    logic   ident_ch;

    assign ident_ch = i_cls.alpha || i_cls.digit || i_cls.under;

    always_comb begin
        n_mode    = r_mode;
        n_pos     = sat_inc(r_pos, POS_LIMIT);
        n_line    = r_line;
        n_pstart  = r_pstart;
        n_plen    = r_plen;
        n_tulis   = r_tulis;
        n_biar    = r_biar;
        a_vld     = 1'b0;
        b_vld     = 1'b0;
        idle_path = 1'b0;
        a_tok     = '{kind: KIND_STRING, start: r_pstart, length: r_plen,
                      line: r_line, last: 1'b0};
        b_tok     = '{kind: KIND_UNKNOWN, start: r_pos, length: 16'd1,
                      line: r_line, last: 1'b1};

        unique case (r_mode)
            MODE_STRING: begin
                if (i_cls.zero) begin
                    a_vld     = 1'b1;
                    n_mode    = MODE_IDLE;
                    idle_path = 1'b1;
                end else if (i_cls.quote) begin
                    a_vld  = 1'b1;
                    n_mode = MODE_IDLE;
                end else begin
                    n_plen = sat_inc(r_plen, CNT_LIMIT);
                    if (i_cls.newline) begin
                        n_line = sat_inc(r_line, CNT_LIMIT);
                    end
                end
            end
            MODE_NUMBER: begin
                if (i_cls.digit) begin
                    n_plen = sat_inc(r_plen, CNT_LIMIT);
                end else begin
                    a_vld      = 1'b1;
                    a_tok.kind = KIND_NUMBER;
                    n_mode     = MODE_IDLE;
                    idle_path  = 1'b1;
                end
            end
            MODE_IDENT: begin
                if (ident_ch) begin
                    n_tulis = r_tulis && tulis_match(r_plen, i_cls.ch);
                    n_biar  = r_biar && biar_match(r_plen, i_cls.ch);
                    n_plen  = sat_inc(r_plen, CNT_LIMIT);
                end else begin
                    a_vld = 1'b1;
                    priority if (r_plen == TULIS_LEN && r_tulis) begin
                        a_tok.kind = KIND_TULIS;
                    end else if (r_plen == BIAR_LEN && r_biar) begin
                        a_tok.kind = KIND_BIAR;
                    end else begin
                        a_tok.kind = KIND_IDENT;
                    end
                    n_mode    = MODE_IDLE;
                    idle_path = 1'b1;
                end
            end
            MODE_IDLE: begin
                idle_path = 1'b1;
            end
            default: begin
                idle_path = 1'b1;
            end
        endcase

        if (idle_path) begin
            priority if (i_cls.zero) begin
                b_vld        = 1'b1;
                b_tok.kind   = KIND_END;
                b_tok.length = 16'd0;
                n_mode       = MODE_IDLE;
                n_pos        = 16'd0;
                n_line       = 16'd1;
                n_pstart     = 16'd0;
                n_plen       = 16'd0;
                n_tulis      = 1'b1;
                n_biar       = 1'b1;
            end else if (i_cls.space) begin
                if (i_cls.newline) begin
                    n_line = sat_inc(r_line, CNT_LIMIT);
                end
            end else if (i_cls.equals) begin
                b_vld      = 1'b1;
                b_tok.kind = KIND_EQUALS;
            end else if (i_cls.quote) begin
                n_mode   = MODE_STRING;
                n_pstart = sat_inc(r_pos, POS_LIMIT);
                n_plen   = 16'd0;
            end else if (i_cls.digit) begin
                n_mode   = MODE_NUMBER;
                n_pstart = r_pos;
                n_plen   = 16'd1;
            end else if (i_cls.alpha || i_cls.under) begin
                n_mode   = MODE_IDENT;
                n_pstart = r_pos;
                n_plen   = 16'd1;
                n_tulis  = (i_cls.ch == "t");
                n_biar   = (i_cls.ch == "b");
            end else begin
                b_vld = 1'b1;
            end
        end

        a_tok.last = !b_vld;
    end

    // Pack: pending-run token first, then the token of the byte itself.
    always_comb begin
        o_wr0  = i_fire && (a_vld || b_vld);
        o_wr1  = i_fire && a_vld && b_vld;
        o_tok0 = a_vld ? a_tok : b_tok;
        o_tok1 = b_tok;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_IDLE;
            r_pos    <= 16'd0;
            r_line   <= 16'd1;
            r_pstart <= 16'd0;
            r_plen   <= 16'd0;
            r_tulis  <= 1'b1;
            r_biar   <= 1'b1;
        end else if (i_fire) begin
            r_mode   <= n_mode;
            r_pos    <= n_pos;
            r_line   <= n_line;
            r_pstart <= n_pstart;
            r_plen   <= n_plen;
            r_tulis  <= n_tulis;
            r_biar   <= n_biar;
        end
    end

endmodule

// File: src/source_text_tokenizer.sv
// Source text tokenizer: one byte per cycle in, tokens out through a queue.
// Path: byte queue, then scanner, which writes tokens into the token queue.
// Throughput: one byte per cycle; the scanner holds a byte while the token queue
// has fewer than two free entries, and the byte queue then fills up to four.
// Reset: synchronous, active low; empties both queues, line back to one, offset zero.
// Depends on stt_pkg, stt_classify, stt_cls_fifo, stt_scan, stt_tok_fifo.
module source_text_tokenizer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_text_byte,
    input  logic        pop,
    output logic        empty,
    output logic [2:0]  o_token_kind,
    output logic [15:0] o_lexeme_start,
    output logic [15:0] o_lexeme_length,
    output logic [15:0] o_line_number,
    output logic        o_last_of_run
);
    import stt_pkg::*;

    t_cls   cls_in;
    t_cls   cls_head;
    logic   cls_empty;
    logic   tok_room2;
    logic   fire;
    logic   wr0, wr1;
    t_token tok0, tok1;
    t_token tok_head;

    stt_classify u_classify (
        .i_byte (i_text_byte),
        .o_cls  (cls_in)
    );

    stt_cls_fifo u_cls_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (cls_in),
        .o_full  (full),
        .i_pop   (fire),
        .o_empty (cls_empty),
        .o_data  (cls_head)
    );

    assign fire = !cls_empty && tok_room2;

    stt_scan u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_cls   (cls_head),
        .o_wr0   (wr0),
        .o_tok0  (tok0),
        .o_wr1   (wr1),
        .o_tok1  (tok1)
    );

    stt_tok_fifo u_tok_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr0   (wr0),
        .i_tok0  (tok0),
        .i_wr1   (wr1),
        .i_tok1  (tok1),
        .o_room2 (tok_room2),
        .i_pop   (pop),
        .o_empty (empty),
        .o_tok   (tok_head)
    );

    assign o_token_kind    = tok_head.kind;
    assign o_lexeme_start  = tok_head.start;
    assign o_lexeme_length = tok_head.length;
    assign o_line_number   = tok_head.line;
    assign o_last_of_run   = tok_head.last;

endmodule
